FILE: hdl/atwa_pkg.sv
// shared constants, register codes and state type of the address table
package atwa_pkg;

    // table geometry
    localparam int CAPACITY = 256;
    localparam int SLOT_W   = 8;
    localparam int CNT_W    = 9;
    localparam int TIME_W   = 32;
    localparam int KEY_W    = 32;

    // config port
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;
    localparam int THR_W    = 9;

    // register codes on paddr[3:2]
    localparam logic [1:0] REG_EXPIRY   = 2'd0;
    localparam logic [1:0] REG_INTERVAL = 2'd1;
    localparam logic [1:0] REG_THRESH   = 2'd2;

    // register reset values
    localparam logic [TIME_W-1:0] EXPIRY_RST   = 32'd3600;
    localparam logic [TIME_W-1:0] INTERVAL_RST = 32'd60;
    localparam logic [THR_W-1:0]  THRESH_RST   = 9'd192;

    // opcodes
    localparam logic OP_ACCESS = 1'b0;
    localparam logic OP_MANAGE = 1'b1;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_EXP,
        ST_MID,
        ST_SRCH,
        ST_CNT,
        ST_DROP,
        ST_EMIT
    } t_state;

endpackage

FILE: hdl/atwa_if.sv
// item and result channel interfaces
interface atwa_in_if;
    logic                          valid;
    logic                          ready;
    logic                          opcode;
    logic [atwa_pkg::KEY_W-1:0]    dest_addr;
    logic [atwa_pkg::TIME_W-1:0]   now;

    modport source (output valid, opcode, dest_addr, now, input ready);
    modport sink   (input valid, opcode, dest_addr, now, output ready);
endinterface

interface atwa_out_if;
    logic                          valid;
    logic                          ready;
    logic                          hit;
    logic [atwa_pkg::SLOT_W-1:0]   slot;
    logic                          full_res;
    logic [atwa_pkg::CNT_W-1:0]    removed_count;
    logic [atwa_pkg::CNT_W-1:0]    occupancy;

    modport source (output valid, hit, slot, full_res, removed_count, occupancy,
                    input ready);
    modport sink   (input valid, hit, slot, full_res, removed_count, occupancy,
                    output ready);
endinterface

FILE: hdl/atwa_ram.sv
// generic single write port ram with registered read
module atwa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hdl/address_table_with_aging.sv
// address table with aging: top level
//
//  channel  dir  handshake        payload
//  i_in     in   valid/ready      opcode, dest_addr, now
//  o_out    out  valid/ready      hit, slot, full_res, removed_count, occupancy
//  apb      in   psel/penable     expiry_age, sweep_interval, size_threshold
//
// every pass walks all 256 slots through the key and stamp rams, one slot a
// cycle, with registered reads; access: one pass, ending early on a hit
// manage: optional expiry pass, then, above the size threshold, a trim of up
// to 34 passes (32 for the stamp search, one count, one drop)
// one item in flight; a result waits in the output register while the next
// item is taken; reset clears valid bits at once, no clearing pass
module address_table_with_aging (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    atwa_in_if.sink                        i_in,
    atwa_out_if.source                     o_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [atwa_pkg::PADDR_W-1:0]   paddr,
    input  logic [atwa_pkg::PDATA_W-1:0]   pwdata,
    output logic [atwa_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);
    import atwa_pkg::*;

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic                  r_pv, n_pv;
    logic [SLOT_W-1:0]     r_pidx, n_pidx;
    logic [CAPACITY-1:0]   r_valid, n_valid;
    logic [CNT_W-1:0]      r_vcount, n_vcount;
    logic [TIME_W-1:0]     r_last, n_last;
    logic [TIME_W-1:0]     r_exp, r_int;
    logic [THR_W-1:0]      r_thr;
    logic [KEY_W-1:0]      r_addr, n_addr;
    logic [TIME_W-1:0]     r_now, n_now;
    logic                  r_free_ok, n_free_ok;
    logic [SLOT_W-1:0]     r_free, n_free;
    logic [TIME_W-1:0]     r_t, n_t;
    logic [4:0]            r_bit, n_bit;
    logic [CNT_W-1:0]      r_gt, n_gt;
    logic [CNT_W-1:0]      r_need, n_need;
    logic [CNT_W-1:0]      r_eq, n_eq;
    logic [CNT_W-1:0]      r_rem, n_rem;
    logic                  r_res_hit, n_res_hit;
    logic                  r_res_full, n_res_full;
    logic [SLOT_W-1:0]     r_res_slot, n_res_slot;
    logic                  r_ovalid, n_ovalid;
    logic                  r_ohit, r_ofull;
    logic [SLOT_W-1:0]     r_oslot;
    logic [CNT_W-1:0]      r_orem, r_oocc;
    logic                  load_out;

    logic                  key_we, stamp_we;
    logic [SLOT_W-1:0]     key_waddr, stamp_waddr;
    logic [KEY_W-1:0]      key_wdata;
    logic [TIME_W-1:0]     stamp_wdata;
    logic [KEY_W-1:0]      rd_key;
    logic [TIME_W-1:0]     rd_stamp;

    logic                  in_beat, pass_last, v_cur, cfg_wr;
    logic [SLOT_W-1:0]     keep;
    logic [TIME_W-1:0]     tc;
    logic [CNT_W-1:0]      gt_now;

    // key and stamp stores
    atwa_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (key_waddr),
        .i_wdata (key_wdata),
        .i_raddr (r_cnt[SLOT_W-1:0]),
        .o_rdata (rd_key)
    );

    atwa_ram #(.WIDTH(TIME_W), .DEPTH(CAPACITY)) u_stamp_ram (
        .i_clk   (i_clk),
        .i_we    (stamp_we),
        .i_waddr (stamp_waddr),
        .i_wdata (stamp_wdata),
        .i_raddr (r_cnt[SLOT_W-1:0]),
        .o_rdata (rd_stamp)
    );

    // apb register file
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        unique case (paddr[3:2])
            REG_EXPIRY:   prdata = r_exp;
            REG_INTERVAL: prdata = r_int;
            REG_THRESH:   prdata = PDATA_W'(r_thr);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp <= EXPIRY_RST;
            r_int <= INTERVAL_RST;
            r_thr <= THRESH_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_EXPIRY:   r_exp <= pwdata;
                REG_INTERVAL: r_int <= pwdata;
                REG_THRESH:   r_thr <= pwdata[THR_W-1:0];
                default:      ;
            endcase
        end
    end

    // handshake and per-slot helpers
    assign i_in.ready = (r_state == ST_IDLE);
    assign in_beat    = i_in.valid && (r_state == ST_IDLE);
    assign pass_last  = r_pv && (r_cnt == CNT_W'(CAPACITY));
    assign v_cur      = r_valid[r_pidx];
    assign keep       = r_thr[THR_W-1:1];
    assign tc         = r_t | ~({TIME_W{1'b1}} << r_bit);
    assign load_out   = (r_state == ST_EMIT) && (!r_ovalid || o_out.ready);

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_pv       = 1'b0;
        n_pidx     = r_pidx;
        n_valid    = r_valid;
        n_vcount   = r_vcount;
        n_last     = r_last;
        n_addr     = r_addr;
        n_now      = r_now;
        n_free_ok  = r_free_ok;
        n_free     = r_free;
        n_t        = r_t;
        n_bit      = r_bit;
        n_gt       = r_gt;
        n_need     = r_need;
        n_eq       = r_eq;
        n_rem      = r_rem;
        n_res_hit  = r_res_hit;
        n_res_full = r_res_full;
        n_res_slot = r_res_slot;
        n_ovalid   = r_ovalid;
        key_we      = 1'b0;
        stamp_we    = 1'b0;
        key_waddr   = r_pidx;
        stamp_waddr = r_pidx;
        key_wdata   = r_addr;
        stamp_wdata = r_now;
        gt_now      = r_gt;

        if (o_out.ready) begin
            n_ovalid = 1'b0;
        end

        // slot walk shared by all passes
        if (r_state != ST_IDLE && r_state != ST_MID && r_state != ST_EMIT) begin
            if (r_cnt != CNT_W'(CAPACITY)) begin
                n_cnt  = r_cnt + 1'b1;
                n_pv   = 1'b1;
                n_pidx = r_cnt[SLOT_W-1:0];
            end
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_beat) begin
                    n_addr     = i_in.dest_addr;
                    n_now      = i_in.now;
                    n_rem      = '0;
                    n_res_hit  = 1'b0;
                    n_res_full = 1'b0;
                    n_res_slot = '0;
                    n_cnt      = '0;
                    n_free_ok  = 1'b0;
                    if (i_in.opcode == OP_ACCESS) begin
                        n_state = ST_ACC;
                    end else if (r_last < (i_in.now - r_int)) begin
                        n_last  = i_in.now;
                        n_state = ST_EXP;
                    end else begin
                        n_state = ST_MID;
                    end
                end
            end
            ST_ACC: begin
                if (r_pv && v_cur && rd_key == r_addr) begin
                    stamp_we   = 1'b1;
                    n_res_hit  = 1'b1;
                    n_res_slot = r_pidx;
                    n_state    = ST_EMIT;
                end else begin
                    if (r_pv && !v_cur && !r_free_ok) begin
                        n_free_ok = 1'b1;
                        n_free    = r_pidx;
                    end
                    if (pass_last) begin
                        if (n_free_ok) begin
                            key_we      = 1'b1;
                            stamp_we    = 1'b1;
                            key_waddr   = n_free;
                            stamp_waddr = n_free;
                            n_valid[n_free] = 1'b1;
                            n_vcount   = r_vcount + 1'b1;
                            n_res_slot = n_free;
                        end else begin
                            n_res_full = 1'b1;
                        end
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_EXP: begin
                if (r_pv && v_cur && (rd_stamp + r_exp) < r_now) begin
                    n_valid[r_pidx] = 1'b0;
                    n_rem    = r_rem + 1'b1;
                    n_vcount = r_vcount - 1'b1;
                end
                if (pass_last) begin
                    n_state = ST_MID;
                end
            end
            ST_MID: begin
                n_cnt = '0;
                n_gt  = '0;
                if (r_vcount > r_thr) begin
                    if (keep == '0) begin
                        n_t     = '1;
                        n_state = ST_CNT;
                    end else begin
                        n_t     = '0;
                        n_bit   = 5'd31;
                        n_state = ST_SRCH;
                    end
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_SRCH: begin
                // bitwise search for the keep-th largest stamp
                if (r_pv && v_cur && rd_stamp > tc) begin
                    gt_now = r_gt + 1'b1;
                end
                n_gt = gt_now;
                if (pass_last) begin
                    if (!(gt_now < CNT_W'(keep))) begin
                        n_t = r_t | (TIME_W'(1) << r_bit);
                    end
                    n_gt  = '0;
                    n_cnt = '0;
                    if (r_bit == 5'd0) begin
                        n_state = ST_CNT;
                    end else begin
                        n_bit = r_bit - 1'b1;
                    end
                end
            end
            ST_CNT: begin
                if (r_pv && v_cur && rd_stamp > r_t) begin
                    gt_now = r_gt + 1'b1;
                end
                n_gt = gt_now;
                if (pass_last) begin
                    n_need  = CNT_W'(keep) - gt_now;
                    n_eq    = '0;
                    n_cnt   = '0;
                    n_state = ST_DROP;
                end
            end
            ST_DROP: begin
                if (r_pv && v_cur) begin
                    if (rd_stamp > r_t) begin
                        n_eq = r_eq;
                    end else if (rd_stamp == r_t && r_eq < r_need) begin
                        n_eq = r_eq + 1'b1;
                    end else begin
                        n_valid[r_pidx] = 1'b0;
                        n_rem    = r_rem + 1'b1;
                        n_vcount = r_vcount - 1'b1;
                    end
                end
                if (pass_last) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (load_out) begin
                    n_ovalid = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_pv     <= 1'b0;
            r_valid  <= '0;
            r_vcount <= '0;
            r_last   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pv     <= n_pv;
            r_valid  <= n_valid;
            r_vcount <= n_vcount;
            r_last   <= n_last;
            r_ovalid <= n_ovalid;
        end
    end

    // working and payload registers
    always_ff @(posedge i_clk) begin
        r_cnt      <= n_cnt;
        r_pidx     <= n_pidx;
        r_addr     <= n_addr;
        r_now      <= n_now;
        r_free_ok  <= n_free_ok;
        r_free     <= n_free;
        r_t        <= n_t;
        r_bit      <= n_bit;
        r_gt       <= n_gt;
        r_need     <= n_need;
        r_eq       <= n_eq;
        r_rem      <= n_rem;
        r_res_hit  <= n_res_hit;
        r_res_full <= n_res_full;
        r_res_slot <= n_res_slot;
        if (load_out) begin
            r_ohit  <= r_res_hit;
            r_oslot <= r_res_slot;
            r_ofull <= r_res_full;
            r_orem  <= r_rem;
            r_oocc  <= r_vcount;
        end
    end

    // result beat
    assign o_out.valid         = r_ovalid;
    assign o_out.hit           = r_ohit;
    assign o_out.slot          = r_oslot;
    assign o_out.full_res      = r_ofull;
    assign o_out.removed_count = r_orem;
    assign o_out.occupancy     = r_oocc;
endmodule

FILE: hdl/atwa_chk.sv
// port-level checker for the address table, bound to the top level
module atwa_chk (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic                          hit,
    input logic                          full_res,
    input logic [atwa_pkg::CNT_W-1:0]    removed_count,
    input logic [atwa_pkg::CNT_W-1:0]    occupancy
);
    import atwa_pkg::*;

    // a stalled result beat stays
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    // hit and full never together
    a_hit_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(hit && full_res))
        else $error("hit and full_res both set");

    // full only when every slot is taken
    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && full_res |-> occupancy == CNT_W'(CAPACITY))
        else $error("full_res with free slots");

    // access results remove nothing
    a_hit_rem: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (hit || full_res) |-> removed_count == '0)
        else $error("access result reports removals");

    // occupancy and removals fit in the table
    a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> occupancy <= CNT_W'(CAPACITY) &&
                      removed_count <= CNT_W'(CAPACITY))
        else $error("count beyond capacity");
endmodule

bind address_table_with_aging atwa_chk u_atwa_chk (
    .clk           (i_clk),
    .rst_n         (i_rst_n),
    .out_valid     (o_out.valid),
    .out_ready     (o_out.ready),
    .hit           (o_out.hit),
    .full_res      (o_out.full_res),
    .removed_count (o_out.removed_count),
    .occupancy     (o_out.occupancy)
);
